FILE: rtl/fsr_pkg.sv
// ----------------------------------------------------------------------------
// fsr_pkg
// Shared types and fixed-point constants for the Schlick Fresnel pipeline.
// ----------------------------------------------------------------------------
package fsr_pkg;

   localparam int WORK_BITS = 30;
   localparam int QUO_BITS  = WORK_BITS + 1;
   localparam logic [30:0] WORK_ONE = 31'd1 << WORK_BITS;

   // one stage of the two restoring dividers running side by side
   typedef struct packed {
      logic [30:0] c_orig;
      logic        gt;
      logic        tir;
      logic        den_zero;
      logic        sum_zero;
      logic [62:0] rem_a;
      logic [31:0] den;
      logic [30:0] quo_a;
      logic [63:0] rem_b;
      logic [33:0] sum_sq;
      logic [30:0] quo_b;
   } div_stage_type;

   // one stage of the restoring square root
   typedef struct packed {
      logic [60:0] rem;
      logic [30:0] root;
      logic [30:0] c_orig;
      logic        gt;
      logic        tir;
      logic [30:0] r0;
   } sqrt_stage_type;

endpackage

FILE: rtl/fresnel_schlick_reflectance_top.sv
// ----------------------------------------------------------------------------
// fresnel_schlick_reflectance_top
// Schlick approximation of Fresnel reflectance with total internal reflection.
// ----------------------------------------------------------------------------
// Takes one item per cycle while req_tready is high and delivers one result
// per item, in order. An item passes through five front stages for the
// squares and the reflection test, 31 restoring divider stages (one quotient
// bit each, shared by sin^2 and r0), 32 square root stages (an entry stage,
// then one root bit each), five stages for the power and blend, and the output
// register. A two-entry output (register plus skid) lets the input keep flowing
// while a result waits; the pipeline holds only once the skid entry is occupied.
module fresnel_schlick_reflectance_top #(
   parameter int COS_FRAC_BITS = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // cos_incident, index_from, index_to
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // reflectance
   output logic [0:0]  rsp_tuser    // total_internal
);

   localparam int SH = fsr_pkg::WORK_BITS - COS_FRAC_BITS;
   localparam int HALF_SH = (SH == 0) ? 0 : SH - 1;
   localparam logic [32:0] HALF = (SH > 0) ? (33'd1 << HALF_SH) : 33'd0;
   localparam logic [30:0] COS_ONE = 31'd1 << COS_FRAC_BITS;
   localparam int NDIV = fsr_pkg::QUO_BITS;

   logic en;

   // front stage registers
   logic        s0_v_ff, s1_v_ff, s2_v_ff, s3_v_ff;
   logic [30:0] s0_c_ff, s1_c_ff, s2_c_ff, s3_c_ff;
   logic [15:0] s0_n1_ff, s0_n2_ff;
   logic [61:0] s1_cc_ff;
   logic [31:0] s1_n1sq_ff, s1_n2sq_ff, s2_n1sq_ff, s2_n2sq_ff, s3_den_ff;
   logic [15:0] s1_d_ff;
   logic [16:0] s1_s_ff;
   logic        s1_gt_ff, s2_gt_ff, s3_gt_ff;
   logic [30:0] s2_omc2_ff;
   logic [31:0] s2_d2_ff, s3_d2_ff;
   logic [33:0] s2_s2_ff, s3_s2_ff;
   logic [62:0] s3_num_ff;

   logic [15:0] c_raw;
   logic [30:0] c_sat;

   fsr_pkg::div_stage_type  div_ff [0:NDIV];
   fsr_pkg::div_stage_type  div_in [0:NDIV];
   logic                    div_v_ff [0:NDIV];
   fsr_pkg::sqrt_stage_type sq_ff [0:NDIV];
   fsr_pkg::sqrt_stage_type sq_in [0:NDIV];
   logic                    sq_v_ff [0:NDIV];

   // power and blend stages
   logic        x_v_ff, m2_v_ff, m4_v_ff, m5_v_ff, m6_v_ff;
   logic [30:0] x_x_ff, m2_x_ff, m4_x_ff;
   logic [30:0] x_r0_ff, m2_r0_ff, m4_r0_ff, m5_r0_ff, m6_r0_ff;
   logic [30:0] x_omr0_ff, m2_omr0_ff, m4_omr0_ff, m5_omr0_ff;
   logic        x_tir_ff, m2_tir_ff, m4_tir_ff, m5_tir_ff, m6_tir_ff;
   logic [30:0] m2_x2_ff, m4_x4_ff, m5_x5_ff, m6_p_ff;
   logic [30:0] c_sel;
   logic [61:0] x2_full, x4_full, x5_full, p_full;

   // output register and skid
   logic        out_v_ff, skid_v_ff;
   logic [15:0] out_r_ff, skid_r_ff;
   logic        out_t_ff, skid_t_ff;
   logic [31:0] val_sum;
   logic [32:0] val_rnd;
   logic [15:0] res_r;
   logic        out_take;

   assign en         = !skid_v_ff;
   assign req_tready = en;

   assign c_raw = req_tdata[15:0];
   assign c_sat = (31'(c_raw) > COS_ONE) ? (COS_ONE << SH) : (31'(c_raw) << SH);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff <= req_tvalid;
         s1_v_ff <= s0_v_ff;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_c_ff    <= c_sat;
         s0_n1_ff   <= req_tdata[31:16];
         s0_n2_ff   <= req_tdata[47:32];
         s1_c_ff    <= s0_c_ff;
         s1_cc_ff   <= 62'(s0_c_ff) * 62'(s0_c_ff);
         s1_n1sq_ff <= 32'(s0_n1_ff) * 32'(s0_n1_ff);
         s1_n2sq_ff <= 32'(s0_n2_ff) * 32'(s0_n2_ff);
         s1_gt_ff   <= s0_n1_ff > s0_n2_ff;
         s1_d_ff    <= (s0_n1_ff > s0_n2_ff) ? s0_n1_ff - s0_n2_ff : s0_n2_ff - s0_n1_ff;
         s1_s_ff    <= 17'(s0_n1_ff) + 17'(s0_n2_ff);
         s2_c_ff    <= s1_c_ff;
         s2_omc2_ff <= fsr_pkg::WORK_ONE - s1_cc_ff[60:30];
         s2_n1sq_ff <= s1_n1sq_ff;
         s2_n2sq_ff <= s1_n2sq_ff;
         s2_gt_ff   <= s1_gt_ff;
         s2_d2_ff   <= 32'(s1_d_ff) * 32'(s1_d_ff);
         s2_s2_ff   <= 34'(s1_s_ff) * 34'(s1_s_ff);
         s3_c_ff    <= s2_c_ff;
         s3_num_ff  <= 63'(s2_n1sq_ff) * 63'(s2_omc2_ff);
         s3_den_ff  <= s2_n2sq_ff;
         s3_gt_ff   <= s2_gt_ff;
         s3_d2_ff   <= s2_d2_ff;
         s3_s2_ff   <= s2_s2_ff;
      end
   end

   // divider entry: reflection test and initial remainders
   always_comb begin
      div_in[0]          = '0;
      div_in[0].c_orig   = s3_c_ff;
      div_in[0].gt       = s3_gt_ff;
      div_in[0].tir      = s3_gt_ff && (s3_num_ff > {1'b0, s3_den_ff, 30'd0});
      div_in[0].den_zero = (s3_den_ff == '0);
      div_in[0].sum_zero = (s3_s2_ff == '0);
      div_in[0].rem_a    = s3_num_ff;
      div_in[0].den      = s3_den_ff;
      div_in[0].rem_b    = {2'b00, s3_d2_ff, 30'd0};
      div_in[0].sum_sq   = s3_s2_ff;
   end

   genvar j;
   generate
      for (j = 0; j < NDIV; j++) begin : g_div
         localparam int B = fsr_pkg::WORK_BITS - j;
         logic [62:0] sub_a;
         logic [63:0] sub_b;
         always_comb begin
            sub_a     = 63'(div_ff[j].den) << B;
            sub_b     = 64'(div_ff[j].sum_sq) << B;
            div_in[j+1] = div_ff[j];
            if (div_ff[j].rem_a >= sub_a) begin
               div_in[j+1].rem_a    = div_ff[j].rem_a - sub_a;
               div_in[j+1].quo_a[B] = 1'b1;
            end
            if (div_ff[j].rem_b >= sub_b) begin
               div_in[j+1].rem_b    = div_ff[j].rem_b - sub_b;
               div_in[j+1].quo_b[B] = 1'b1;
            end
         end
      end
   endgenerate

   // square root entry: arg = (1 - sin^2) in Q60
   always_comb begin
      logic [30:0] sin2t;
      sin2t           = div_ff[NDIV].den_zero ? 31'd0 : div_ff[NDIV].quo_a;
      sq_in[0]        = '0;
      sq_in[0].rem    = {fsr_pkg::WORK_ONE - sin2t, 30'd0};
      sq_in[0].c_orig = div_ff[NDIV].c_orig;
      sq_in[0].gt     = div_ff[NDIV].gt;
      sq_in[0].tir    = div_ff[NDIV].tir;
      sq_in[0].r0     = div_ff[NDIV].sum_zero ? 31'd0 : div_ff[NDIV].quo_b;
   end

   genvar k;
   generate
      for (k = 0; k < NDIV; k++) begin : g_sqrt
         localparam int B = fsr_pkg::WORK_BITS - k;
         logic [62:0] trial;
         always_comb begin
            trial      = ((63'(sq_ff[k].root) << 1) + (63'd1 << B)) << B;
            sq_in[k+1] = sq_ff[k];
            if (63'(sq_ff[k].rem) >= trial) begin
               sq_in[k+1].rem     = sq_ff[k].rem - trial[60:0];
               sq_in[k+1].root[B] = 1'b1;
            end
         end
      end
   endgenerate

   genvar i;
   generate
      for (i = 0; i <= NDIV; i++) begin : g_regs
         always_ff @(posedge clock) begin
            if (reset) begin
               div_v_ff[i] <= 1'b0;
               sq_v_ff[i]  <= 1'b0;
            end else if (en) begin
               div_v_ff[i] <= (i == 0) ? s3_v_ff : div_v_ff[(i == 0) ? 0 : i - 1];
               sq_v_ff[i]  <= (i == 0) ? div_v_ff[NDIV] : sq_v_ff[(i == 0) ? 0 : i - 1];
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               div_ff[i] <= div_in[i];
               sq_ff[i]  <= sq_in[i];
            end
         end
      end
   endgenerate

   assign c_sel   = sq_ff[NDIV].gt ? sq_ff[NDIV].root : sq_ff[NDIV].c_orig;
   assign x2_full = 62'(x_x_ff) * 62'(x_x_ff);
   assign x4_full = 62'(m2_x2_ff) * 62'(m2_x2_ff);
   assign x5_full = 62'(m4_x4_ff) * 62'(m4_x_ff);
   assign p_full  = 62'(m5_omr0_ff) * 62'(m5_x5_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         x_v_ff  <= 1'b0;
         m2_v_ff <= 1'b0;
         m4_v_ff <= 1'b0;
         m5_v_ff <= 1'b0;
         m6_v_ff <= 1'b0;
      end else if (en) begin
         x_v_ff  <= sq_v_ff[NDIV];
         m2_v_ff <= x_v_ff;
         m4_v_ff <= m2_v_ff;
         m5_v_ff <= m4_v_ff;
         m6_v_ff <= m5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_x_ff     <= fsr_pkg::WORK_ONE - c_sel;
         x_r0_ff    <= sq_ff[NDIV].r0;
         x_omr0_ff  <= fsr_pkg::WORK_ONE - sq_ff[NDIV].r0;
         x_tir_ff   <= sq_ff[NDIV].tir;
         m2_x2_ff   <= x2_full[60:30];
         m2_x_ff    <= x_x_ff;
         m2_r0_ff   <= x_r0_ff;
         m2_omr0_ff <= x_omr0_ff;
         m2_tir_ff  <= x_tir_ff;
         m4_x4_ff   <= x4_full[60:30];
         m4_x_ff    <= m2_x_ff;
         m4_r0_ff   <= m2_r0_ff;
         m4_omr0_ff <= m2_omr0_ff;
         m4_tir_ff  <= m2_tir_ff;
         m5_x5_ff   <= x5_full[60:30];
         m5_r0_ff   <= m4_r0_ff;
         m5_omr0_ff <= m4_omr0_ff;
         m5_tir_ff  <= m4_tir_ff;
         m6_p_ff    <= p_full[60:30];
         m6_r0_ff   <= m5_r0_ff;
         m6_tir_ff  <= m5_tir_ff;
      end
   end

   // round half up into the output format, clamp to one
   assign val_sum = 32'(m6_r0_ff) + 32'(m6_p_ff);
   assign val_rnd = (33'(val_sum) + HALF) >> SH;
   assign res_r   = (m6_tir_ff || (val_rnd > 33'(COS_ONE))) ? COS_ONE[15:0] : val_rnd[15:0];

   assign out_take = !out_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (out_take) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end
      end else if (out_take) begin
         out_v_ff <= m6_v_ff;
      end else if (m6_v_ff) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (out_take) begin
            out_r_ff <= skid_r_ff;
            out_t_ff <= skid_t_ff;
         end
      end else if (out_take) begin
         out_r_ff <= res_r;
         out_t_ff <= m6_tir_ff;
      end else begin
         // hold the finished result aside while the output waits
         skid_r_ff <= res_r;
         skid_t_ff <= m6_tir_ff;
      end
   end

   assign rsp_tvalid   = out_v_ff;
   assign rsp_tdata    = out_r_ff;
   assign rsp_tuser[0] = out_t_ff;

endmodule

FILE: rtl/fsr_checker.sv
// ----------------------------------------------------------------------------
// fsr_checker
// Port-level checks for the Fresnel reflectance block, bound to the top.
// ----------------------------------------------------------------------------
module fsr_checker #(
   parameter int COS_FRAC_BITS = 15
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   localparam logic [30:0] COS_ONE = 31'd1 << COS_FRAC_BITS;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before transfer");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("input changed while waiting for transfer");

   a_tir_one: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == COS_ONE[15:0])
      else $error("total internal reflection without full reflectance");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (COS_FRAC_BITS < 16) |-> 31'(rsp_tdata) <= COS_ONE)
      else $error("reflectance above one");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind fresnel_schlick_reflectance_top fsr_checker #(.COS_FRAC_BITS(COS_FRAC_BITS)) u_fsr_checker (.*);

FILE: dv/fresnel_schlick_reflectance_top_tb.sv
// ----------------------------------------------------------------------------
// fresnel_schlick_reflectance_top_tb
// Self-checking bench for the Schlick Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
// Drives directed corner items (cosine limits, equal, swapped and degenerate
// indices, total internal reflection borders) and then random hits, mostly
// in the physical range, under several idle/stall mixes. A bit-exact
// integer predictor queues expected results, which are checked in order.
// ----------------------------------------------------------------------------
class reflectance_scoreboard;
   logic [15:0] exp_refl[$];
   logic        exp_tir[$];
   int          mismatches;
   int          checked;
   int          tir_seen;

   static function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function void note_hit(logic [15:0] cos_in, logic [15:0] n1_in, logic [15:0] n2_in);
      localparam longint unsigned ONE = 64'd1 << 30;
      localparam longint unsigned COS_ONE = 64'd1 << 15;
      longint unsigned c, n1, n2, omc2, num, den, s2t, d, s, r0, x, x2, x4, x5, val;
      c  = cos_in;
      n1 = n1_in;
      n2 = n2_in;
      if (c > COS_ONE) c = COS_ONE;
      c = c << 15;
      if (n1 > n2) begin
         omc2 = ONE - ((c * c) >> 30);
         num  = n1 * n1 * omc2;
         den  = n2 * n2;
         if (num > (den << 30)) begin
            exp_refl = {exp_refl, 16'(COS_ONE)};
            exp_tir  = {exp_tir, 1'b1};
            return;
         end
         s2t = (den != 0) ? num / den : 0;
         if (s2t > ONE) s2t = ONE;
         c = int_sqrt((ONE - s2t) << 30);
         if (c > ONE) c = ONE;
      end
      d  = (n1 > n2) ? n1 - n2 : n2 - n1;
      s  = n1 + n2;
      r0 = (s != 0) ? ((d * d) << 30) / (s * s) : 0;
      if (r0 > ONE) r0 = ONE;
      x   = ONE - c;
      x2  = (x * x) >> 30;
      x4  = (x2 * x2) >> 30;
      x5  = (x4 * x) >> 30;
      val = r0 + (((ONE - r0) * x5) >> 30);
      val = (val + (64'd1 << 14)) >> 15;
      if (val > COS_ONE) val = COS_ONE;
      exp_refl = {exp_refl, val[15:0]};
      exp_tir  = {exp_tir, 1'b0};
   endfunction

   function void check_result(logic [15:0] refl, logic tir);
      logic [15:0] er;
      logic        et;
      if (exp_refl.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result refl=%0d tir=%0b", refl, tir);
         return;
      end
      er = exp_refl.pop_front();
      et = exp_tir.pop_front();
      checked++;
      if (tir) tir_seen++;
      if (er !== refl || et !== tir) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result %0d: expected refl=%0d tir=%0b, got refl=%0d tir=%0b",
                     checked, er, et, refl, tir);
      end
   endfunction
endclass

module fresnel_schlick_reflectance_top_tb;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   reflectance_scoreboard hits = new();
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int quiet_cycles   = 0;
   int sent           = 0;

   fresnel_schlick_reflectance_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // sample transfers at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            hits.note_hit(req_tdata[15:0], req_tdata[31:16], req_tdata[47:32]);
         if (rsp_tvalid && rsp_tready)
            hits.check_result(rsp_tdata, rsp_tuser[0]);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 2000) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // receiver stalls change at the falling edge
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   task automatic send_hit(logic [15:0] c, logic [15:0] n1, logic [15:0] n2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {n2, n1, c};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic send_random_hit();
      logic [15:0] c, n1, n2;
      int kind;
      kind = $urandom_range(9);
      c  = (kind == 0) ? 16'($urandom) : 16'($urandom_range(32768));
      if (kind <= 1) begin
         n1 = 16'($urandom);
         n2 = 16'($urandom);
      end else begin
         n1 = 16'($urandom_range(4096, 12288));
         n2 = 16'($urandom_range(4096, 12288));
         if (kind == 2) n2 = n1;
      end
      send_hit(c, n1, n2);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (hits.exp_refl.size() != 0) @(negedge clock);
   endtask

   initial begin
      logic [15:0] dir_c[10];
      int phase;
      dir_c = '{16'd0, 16'd1, 16'd16384, 16'd23170, 16'd32767, 16'd32768,
                16'd32769, 16'hFFFF, 16'd8000, 16'd30000};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners
      foreach (dir_c[i]) send_hit(dir_c[i], 16'd6144, 16'd4096);
      send_hit(16'd0, 16'd4096, 16'd6144);
      send_hit(16'd32768, 16'd4096, 16'd4096);
      send_hit(16'd100, 16'hFFFF, 16'hFFFF);
      send_hit(16'd32767, 16'd1, 16'd0);
      send_hit(16'd32768, 16'd1, 16'd0);
      send_hit(16'd20000, 16'd0, 16'd0);
      send_hit(16'd0, 16'd0, 16'hFFFF);
      send_hit(16'd32768, 16'hFFFF, 16'd4096);
      send_hit(16'd16000, 16'hFFFF, 16'd1);
      send_hit(16'd28378, 16'd6144, 16'd4096);
      send_hit(16'd12345, 16'hAAAA, 16'h5555);
      drain();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 50; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 50; end
            default: begin send_idle_pct = 13; stall_pct = 13; end
         endcase
         repeat (350) send_random_hit();
         // after the idle-heavy phase, hold the input until everything in flight has come back
         if (phase == 1) drain();
      end
      drain();
      repeat (100) @(negedge clock);
      $display("covered %0d hits, %0d checked, %0d with total internal reflection",
               sent, hits.checked, hits.tir_seen);
      if (hits.mismatches == 0 && hits.exp_refl.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
